>>> design/tfn_pkg.sv
package tfn_pkg;

   // default field widths
   localparam int COORD_WIDTH_DEF      = 24;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   // the largest normalized cross product magnitude has its top bit here
   localparam int NORM_MSB = 29;
   // root bits of a sum of three squares below 2^62
   localparam int SQRT_STEPS = 31;
   localparam int SQ_REM_W   = 62;
   localparam int SQ_ROOT_W  = 63;

   // data that rides along with the length computation
   typedef struct packed {
      logic [2:0][NORM_MSB:0] mag;
      logic [2:0]             neg;
      logic                   deg;
   } tfn_side_type;

endpackage

>>> design/triangle_face_normal_unit.sv
// channel  dir  handshake            word
// req      in   req_valid/req_stall  three corners, nine signed coordinates
// rsp      out  rsp_valid/rsp_stall  unit normal x/y/z, degenerate flag
//
// fully pipelined: one triangle per cycle, unless a held result stalls the pipe
// the depth is set by the 31-stage square root and the one-bit-per-stage dividers
// all stages move together; a stalled result freezes the whole pipe
// synchronous active-high reset clears only the valid bits
module triangle_face_normal_unit
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_WIDTH-1:0]        req_p0_x,
   input  logic [COORD_WIDTH-1:0]        req_p0_y,
   input  logic [COORD_WIDTH-1:0]        req_p0_z,
   input  logic [COORD_WIDTH-1:0]        req_p1_x,
   input  logic [COORD_WIDTH-1:0]        req_p1_y,
   input  logic [COORD_WIDTH-1:0]        req_p1_z,
   input  logic [COORD_WIDTH-1:0]        req_p2_x,
   input  logic [COORD_WIDTH-1:0]        req_p2_y,
   input  logic [COORD_WIDTH-1:0]        req_p2_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_normal_x,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_normal_y,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_normal_z,
   output logic                          rsp_degenerate
);

   localparam int ESH = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
   localparam int EW  = (COORD_WIDTH > 30) ? 31 : COORD_WIDTH + 1;
   localparam int PW  = 2 * EW;
   localparam int CW  = PW + 1;
   localparam int LZW = $clog2(CW);
   localparam int SHW = CW + NORM_MSB;
   localparam int OW  = NORMAL_FRAC_BITS + 2;
   localparam int QW  = NORMAL_FRAC_BITS + 1;
   localparam int NW  = NORM_MSB + 1 + NORMAL_FRAC_BITS + 1;
   localparam int LW  = SQRT_STEPS;

   logic adv;

   // whole pipe moves unless a finished word is held
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   function automatic logic signed [EW-1:0] shrink(input logic signed [COORD_WIDTH:0] d);
      logic [COORD_WIDTH:0] a;
      logic [EW-1:0]        t;
      a = d[COORD_WIDTH] ? (~d + 1'b1) : d;
      a = a >> ESH;
      t = a[EW-1:0];
      return d[COORD_WIDTH] ? (~t + 1'b1) : t;
   endfunction

   function automatic logic [LZW-1:0] top_bit(input logic [CW-1:0] v);
      logic [LZW-1:0] p;
      p = '0;
      for (int i = 0; i < CW; i++) begin
         if (v[i]) p = LZW'(i);
      end
      return p;
   endfunction

   function automatic logic signed [COORD_WIDTH:0] diff(input logic [COORD_WIDTH-1:0] a,
                                                        input logic [COORD_WIDTH-1:0] b);
      return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
   endfunction

   // move the magnitude so that bit t lands on NORM_MSB, truncating
   function automatic logic [NORM_MSB:0] norm_mag(input logic [CW-1:0]  m,
                                                  input logic [LZW-1:0] t);
      logic [SHW-1:0] w;
      w = (SHW'(m) << NORM_MSB) >> t;
      return w[NORM_MSB:0];
   endfunction

   // stage 1: edges from corner 0
   logic                        s1_v_ff;
   logic signed [2:0][EW-1:0]   e0_ff, e1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
      if (adv) begin
         e0_ff[0] <= shrink(diff(req_p1_x, req_p0_x));
         e0_ff[1] <= shrink(diff(req_p1_y, req_p0_y));
         e0_ff[2] <= shrink(diff(req_p1_z, req_p0_z));
         e1_ff[0] <= shrink(diff(req_p2_x, req_p0_x));
         e1_ff[1] <= shrink(diff(req_p2_y, req_p0_y));
         e1_ff[2] <= shrink(diff(req_p2_z, req_p0_z));
      end
   end

   // stage 2: six products
   logic                      s2_v_ff;
   logic signed [PW-1:0]      pr_ff [6];
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         pr_ff[0] <= $signed(e0_ff[1]) * $signed(e1_ff[2]);
         pr_ff[1] <= $signed(e0_ff[2]) * $signed(e1_ff[1]);
         pr_ff[2] <= $signed(e0_ff[2]) * $signed(e1_ff[0]);
         pr_ff[3] <= $signed(e0_ff[0]) * $signed(e1_ff[2]);
         pr_ff[4] <= $signed(e0_ff[0]) * $signed(e1_ff[1]);
         pr_ff[5] <= $signed(e0_ff[1]) * $signed(e1_ff[0]);
      end
   end

   // stage 3: cross product
   logic                  s3_v_ff;
   logic signed [CW-1:0]  cr_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            cr_ff[i] <= CW'(pr_ff[2*i]) - CW'(pr_ff[2*i+1]);
         end
      end
   end

   // stage 4: magnitudes, signs, zero test
   logic             s4_v_ff;
   logic [CW-1:0]    mg_ff [3];
   logic [2:0]       s4_neg_ff;
   logic             s4_deg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mg_ff[i]     <= cr_ff[i][CW-1] ? CW'(-cr_ff[i]) : CW'(cr_ff[i]);
            s4_neg_ff[i] <= cr_ff[i][CW-1];
         end
         s4_deg_ff <= (cr_ff[0] == '0) && (cr_ff[1] == '0) && (cr_ff[2] == '0);
      end
   end

   // stage 5: leading one of the largest magnitude
   logic             s5_v_ff;
   logic [CW-1:0]    m5_ff [3];
   logic [LZW-1:0]   top_ff;
   logic [2:0]       s5_neg_ff;
   logic             s5_deg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= s4_v_ff;
      end
      if (adv) begin
         m5_ff     <= mg_ff;
         top_ff    <= top_bit(mg_ff[0] | mg_ff[1] | mg_ff[2]);
         s5_neg_ff <= s4_neg_ff;
         s5_deg_ff <= s4_deg_ff;
      end
   end

   // stage 6: normalize so the top bit lands on NORM_MSB
   logic          s6_v_ff;
   tfn_side_type  s6_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= s5_v_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s6_side_ff.mag[i] <= norm_mag(m5_ff[i], top_ff);
         end
         s6_side_ff.neg <= s5_neg_ff;
         s6_side_ff.deg <= s5_deg_ff;
      end
   end

   // stage 7: squares
   logic                        s7_v_ff;
   logic [2*(NORM_MSB+1)-1:0]   sq_ff [3];
   tfn_side_type                s7_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= s6_v_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= s6_side_ff.mag[i] * s6_side_ff.mag[i];
         end
         s7_side_ff <= s6_side_ff;
      end
   end

   // square root pipeline, one root bit per stage
   logic                   rt_v_ff    [SQRT_STEPS+1];
   logic [SQ_REM_W-1:0]    rt_rem_ff  [SQRT_STEPS+1];
   logic [SQ_ROOT_W-1:0]   rt_root_ff [SQRT_STEPS+1];
   tfn_side_type           rt_side_ff [SQRT_STEPS+1];

   // stage 8: sum of squares
   always_ff @(posedge clock) begin
      if (reset) begin
         rt_v_ff[0] <= 1'b0;
      end else if (adv) begin
         rt_v_ff[0] <= s7_v_ff;
      end
      if (adv) begin
         rt_rem_ff[0]  <= SQ_REM_W'(sq_ff[0]) + SQ_REM_W'(sq_ff[1]) + SQ_REM_W'(sq_ff[2]);
         rt_root_ff[0] <= '0;
         rt_side_ff[0] <= s7_side_ff;
      end
   end

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_root
      localparam logic [SQ_ROOT_W-1:0] BIT = SQ_ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - g));
      logic [SQ_ROOT_W-1:0] trial;
      logic                 take;
      assign trial = rt_root_ff[g] + BIT;
      assign take  = SQ_ROOT_W'(rt_rem_ff[g]) >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            rt_v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            rt_v_ff[g+1] <= rt_v_ff[g];
         end
         if (adv) begin
            rt_rem_ff[g+1]  <= take ? rt_rem_ff[g] - trial[SQ_REM_W-1:0] : rt_rem_ff[g];
            rt_root_ff[g+1] <= take ? (rt_root_ff[g] >> 1) + BIT : rt_root_ff[g] >> 1;
            rt_side_ff[g+1] <= rt_side_ff[g];
         end
      end
   end

   // divider pipeline, one quotient bit per stage, three lanes
   logic              dv_v_ff    [QW+1];
   logic [NW-1:0]     dv_rem_ff  [QW+1][3];
   logic [QW-1:0]     dv_quo_ff  [QW+1][3];
   logic [LW-1:0]     dv_len_ff  [QW+1];
   logic [2:0]        dv_neg_ff  [QW+1];
   logic              dv_deg_ff  [QW+1];
   logic [LW-1:0]     len_w;

   assign len_w = rt_root_ff[SQRT_STEPS][LW-1:0];

   // numerator with half the length for rounding
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= rt_v_ff[SQRT_STEPS];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= (NW'(rt_side_ff[SQRT_STEPS].mag[i]) << NORMAL_FRAC_BITS)
                               + NW'(len_w >> 1);
            dv_quo_ff[0][i] <= '0;
         end
         dv_len_ff[0] <= len_w;
         dv_neg_ff[0] <= rt_side_ff[SQRT_STEPS].neg;
         dv_deg_ff[0] <= rt_side_ff[SQRT_STEPS].deg;
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_div
      localparam int SH = QW - 1 - g;
      logic [NW-1:0] dsr;
      assign dsr = NW'(dv_len_ff[g]) << SH;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[g+1] <= dv_v_ff[g];
         end
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               if (dv_rem_ff[g][i] >= dsr) begin
                  dv_rem_ff[g+1][i] <= dv_rem_ff[g][i] - dsr;
                  dv_quo_ff[g+1][i] <= dv_quo_ff[g][i] | (QW'(1) << SH);
               end else begin
                  dv_rem_ff[g+1][i] <= dv_rem_ff[g][i];
                  dv_quo_ff[g+1][i] <= dv_quo_ff[g][i];
               end
            end
            dv_len_ff[g+1] <= dv_len_ff[g];
            dv_neg_ff[g+1] <= dv_neg_ff[g];
            dv_deg_ff[g+1] <= dv_deg_ff[g];
         end
      end
   end

   // output word: clamp, sign, degenerate fallback
   localparam logic [OW-1:0] ONE = OW'(1) << NORMAL_FRAC_BITS;
   logic                 out_v_ff;
   logic [2:0][OW-1:0]   out_n_ff;
   logic                 out_deg_ff;
   logic [2:0][OW-1:0]   nrm_w;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm_w[i] = OW'(dv_quo_ff[QW][i]);
         if (nrm_w[i] > ONE) nrm_w[i] = ONE;
         if (dv_neg_ff[QW][i]) nrm_w[i] = ~nrm_w[i] + 1'b1;
      end
      if (dv_deg_ff[QW]) begin
         nrm_w[0] = '0;
         nrm_w[1] = ONE;
         nrm_w[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[QW];
      end
      if (adv) begin
         out_n_ff   <= nrm_w;
         out_deg_ff <= dv_deg_ff[QW];
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_normal_x   = out_n_ff[0];
   assign rsp_normal_y   = out_n_ff[1];
   assign rsp_normal_z   = out_n_ff[2];
   assign rsp_degenerate = out_deg_ff;

endmodule
